// ===== rtl/core/tps_pkg.sv =====
`default_nettype none

package tps_pkg;

    localparam int PROC_W  = 4;
    localparam int FIELD_W = 16;
    localparam int TICK_W  = 32;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 56;

    localparam int S_IDX_LSB   = 0;
    localparam int S_RUN_BIT   = 4;
    localparam int S_PRIO_LSB  = 5;
    localparam int S_SLICE_LSB = 21;
    localparam int S_NEST_BIT  = 37;

    localparam int M_PROC_LSB   = 0;
    localparam int M_SLICE_LSB  = 4;
    localparam int M_TICK_LSB   = 20;
    localparam int M_SWITCH_BIT = 52;
    localparam int M_NONE_BIT   = 53;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_BLOCK = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              wr_en;
        logic [PROC_W-1:0] wr_index;
        logic              wr_run;
        logic              dec_en;
        logic              reload;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/tps_cell.sv =====
`default_nettype none

module tps_cell #(
    parameter int NPROC       = 16,
    parameter int SLICE_WIDTH = 16,
    parameter int IDX         = 0
) (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  tps_pkg::cell_ctrl_t         ctrl,
    input  wire [$clog2(NPROC)-1:0]     sel,
    input  wire [SLICE_WIDTH-1:0]       wr_prio,
    input  wire [SLICE_WIDTH-1:0]       wr_slice,
    input  wire [SLICE_WIDTH-1:0]       in_best,
    input  wire [$clog2(NPROC)-1:0]     in_idx,
    input  wire                         in_found,
    output logic [SLICE_WIDTH-1:0]      out_best,
    output logic [$clog2(NPROC)-1:0]    out_idx,
    output logic                        out_found,
    output logic [SLICE_WIDTH-1:0]      slice_out
);
    import tps_pkg::*;

    localparam int IW = $clog2(NPROC);
    localparam int SW = SLICE_WIDTH;

    logic          run_reg;
    logic [SW-1:0] prio_reg;
    logic [SW-1:0] slice_reg;
    logic [SW-1:0] best_reg;
    logic [IW-1:0] idx_reg;
    logic          found_reg;
    logic          take;

    assign take = run_reg && (slice_reg > in_best);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg   <= 1'b0;
            prio_reg  <= '0;
            slice_reg <= '0;
        end else if (ctrl.wr_en && (int'(ctrl.wr_index) == IDX)) begin
            run_reg   <= ctrl.wr_run;
            prio_reg  <= wr_prio;
            slice_reg <= wr_slice;
        end else if (ctrl.reload && run_reg) begin
            slice_reg <= prio_reg;
        end else if (ctrl.dec_en && (sel == IW'(IDX)) && (slice_reg != '0)) begin
            slice_reg <= slice_reg - SW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else begin
            found_reg <= take || in_found;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            best_reg <= slice_reg;
            idx_reg  <= IW'(IDX);
        end else begin
            best_reg <= in_best;
            idx_reg  <= in_idx;
        end
    end

    assign out_best  = best_reg;
    assign out_idx   = idx_reg;
    assign out_found = found_reg;
    assign slice_out = slice_reg;

endmodule

`default_nettype wire

// ===== rtl/core/tick_priority_scheduler.sv =====
`default_nettype none

// Time-slice scheduler over NPROC process entries, one per cell of a compare
// chain. A write, an unused opcode or a tick that needs no reschedule passes
// from idle through the done state into the output register; a reschedule
// walks the whole chain, and walks it again when every runnable slice is spent
// and the slices must be reloaded. One transaction is in work at a time; a
// finished result waits in the output register while the next transaction is
// accepted.
module tick_priority_scheduler #(
    parameter int NPROC       = 16,
    parameter int SLICE_WIDTH = 16
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               cfg_wr_en,
    input  wire [tps_pkg::TICK_W-1:0]         cfg_wr_data,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // proc_index, runnable, prio_value, slice_value, nested, zero fill
    input  wire [tps_pkg::S_TDATA_W-1:0]      s_tdata,
    // opcode
    input  wire [tps_pkg::S_TUSER_W-1:0]      s_tuser,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // current_proc, current_slice, tick_count, switched, none_ready, zero fill
    output logic [tps_pkg::M_TDATA_W-1:0]     m_tdata
);
    import tps_pkg::*;

    localparam int IW = $clog2(NPROC);
    localparam int CW = $clog2(NPROC + 1);
    localparam int SW = SLICE_WIDTH;

    state_t         state_reg, state_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           reloaded_reg, reloaded_next;
    logic [IW-1:0]  sel_reg, sel_next;
    logic           switched_reg, switched_next;
    logic           none_reg, none_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [TICK_W-1:0] limit_reg;
    logic           m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic           load_out;
    logic           reload;
    logic           accept;
    logic [TICK_W:0] tick_inc;
    cell_ctrl_t     ctrl;

    logic [SW-1:0]  best_chain  [NPROC+1];
    logic [IW-1:0]  idx_chain   [NPROC+1];
    logic           found_chain [NPROC+1];
    logic [SW-1:0]  slice_vec   [NPROC];
    logic [SW-1:0]  cur_slice;
    logic [SW-1:0]  wr_prio;
    logic [SW-1:0]  wr_slice;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cur_slice = slice_vec[sel_reg];
    assign wr_prio   = SW'(s_tdata[S_PRIO_LSB +: FIELD_W]);
    assign wr_slice  = SW'(s_tdata[S_SLICE_LSB +: FIELD_W]);

    always_comb begin
        ctrl.wr_en    = accept && (s_tuser == OP_WRITE);
        ctrl.wr_index = s_tdata[S_IDX_LSB +: PROC_W];
        ctrl.wr_run   = s_tdata[S_RUN_BIT];
        ctrl.dec_en   = accept && (s_tuser == OP_TICK);
        ctrl.reload   = reload;
    end

    assign best_chain[0]  = '0;
    assign idx_chain[0]   = '0;
    assign found_chain[0] = 1'b0;

    for (genvar i = 0; i < NPROC; i++) begin : g_cell
        tps_cell #(
            .NPROC       (NPROC),
            .SLICE_WIDTH (SLICE_WIDTH),
            .IDX         (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .sel       (sel_reg),
            .wr_prio   (wr_prio),
            .wr_slice  (wr_slice),
            .in_best   (best_chain[i]),
            .in_idx    (idx_chain[i]),
            .in_found  (found_chain[i]),
            .out_best  (best_chain[i+1]),
            .out_idx   (idx_chain[i+1]),
            .out_found (found_chain[i+1]),
            .slice_out (slice_vec[i])
        );
    end

    assign tick_inc = {1'b0, tick_reg} + (TICK_W+1)'(1);

    always_comb begin
        tick_next = tick_reg;
        if (ctrl.dec_en) begin
            tick_next = (tick_inc >= {1'b0, limit_reg}) ? '0 : tick_inc[TICK_W-1:0];
        end
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        reloaded_next = reloaded_reg;
        sel_next      = sel_reg;
        switched_next = switched_reg;
        none_next     = none_reg;
        reload        = 1'b0;
        load_out      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    switched_next = 1'b0;
                    none_next     = 1'b0;
                    cnt_next      = '0;
                    reloaded_next = 1'b0;
                    case (s_tuser)
                        OP_TICK: begin
                            if (!s_tdata[S_NEST_BIT] && (cur_slice <= SW'(1))) begin
                                state_next = ST_SCAN;
                            end else begin
                                state_next = ST_DONE;
                            end
                        end
                        OP_BLOCK: begin
                            state_next = ST_SCAN;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(NPROC)) begin
                    if (found_chain[NPROC]) begin
                        sel_next      = idx_chain[NPROC];
                        switched_next = 1'b1;
                        state_next    = ST_DONE;
                    end else if (!reloaded_reg) begin
                        reload        = 1'b1;
                        reloaded_next = 1'b1;
                        cnt_next      = '0;
                    end else begin
                        none_next  = 1'b1;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            reloaded_reg <= 1'b0;
            sel_reg      <= '0;
            switched_reg <= 1'b0;
            none_reg     <= 1'b0;
            tick_reg     <= '0;
            limit_reg    <= '1;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            reloaded_reg <= reloaded_next;
            sel_reg      <= sel_next;
            switched_reg <= switched_next;
            none_reg     <= none_next;
            tick_reg     <= tick_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_data_reg <= {2'b00, none_reg, switched_reg, tick_reg,
                           FIELD_W'(cur_slice), PROC_W'(sel_reg)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/tps_checker.sv =====
`default_nettype none

module tps_checker (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               cfg_wr_en,
    input  wire [tps_pkg::TICK_W-1:0]         cfg_wr_data,
    input  wire                               s_tvalid,
    input  wire                               s_tready,
    input  wire [tps_pkg::S_TDATA_W-1:0]      s_tdata,
    input  wire [tps_pkg::S_TUSER_W-1:0]      s_tuser,
    input  wire                               m_tvalid,
    input  wire                               m_tready,
    input  wire [tps_pkg::M_TDATA_W-1:0]      m_tdata
);
    import tps_pkg::*;

    logic cfg_seen;
    logic in_seen;

    assign cfg_seen = cfg_wr_en && (cfg_wr_data != '0 || cfg_wr_data == '0);
    assign in_seen  = (s_tdata != '0 || s_tdata == '0) && (s_tuser != '0 || s_tuser == '0);

    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("Result transaction dropped before it was taken.");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && in_seen |=> !s_tready)
        else $error("Input accepted again while a transaction is in work.");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[M_SWITCH_BIT] && m_tdata[M_NONE_BIT]))
        else $error("Result reports both a switch and no ready process.");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("Result valid right after reset.");

    a_cfg_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_seen && !m_tvalid |=> !m_tvalid)
        else $error("Configuration write produced a result transaction.");

endmodule

bind tick_priority_scheduler tps_checker u_tps_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
);

`default_nettype wire

// ===== test/sched_checker.sv =====
`timescale 1ns / 100ps

module sched_checker
    import tps_pkg::*;
(
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 cfg_wr_en,
    input  wire [TICK_W-1:0]    cfg_wr_data,
    input  wire                 s_tvalid,
    input  wire                 s_tready,
    input  wire [S_TDATA_W-1:0] s_tdata,
    input  wire [S_TUSER_W-1:0] s_tuser,
    input  wire                 m_tvalid,
    input  wire                 m_tready,
    input  wire [M_TDATA_W-1:0] m_tdata,
    output int                  fail_count,
    output int                  pending_cnt
);

    localparam int NUM_PROCS = 16;

    typedef struct packed {
        logic [PROC_W-1:0]  proc;
        logic [FIELD_W-1:0] slice;
        logic [TICK_W-1:0]  tick;
        logic               switched;
        logic               none_ready;
    } sched_status_t;

    logic [FIELD_W-1:0] slice_tab [NUM_PROCS];
    logic [FIELD_W-1:0] prio_tab  [NUM_PROCS];
    logic               run_tab   [NUM_PROCS];
    logic [PROC_W-1:0]  cur_sel;
    logic [TICK_W-1:0]  tick_cnt;
    logic [TICK_W-1:0]  wrap_limit;
    sched_status_t      status_q [$];
    int                 errors;

    initial begin
        errors = 0;
    end

    function automatic logic find_longest(output logic [PROC_W-1:0] which);
        logic [FIELD_W-1:0] best;
        logic               found;
        best  = '0;
        found = 1'b0;
        which = cur_sel;
        for (int i = 0; i < NUM_PROCS; i++) begin
            if (run_tab[i] && slice_tab[i] > best) begin
                best  = slice_tab[i];
                which = PROC_W'(i);
                found = 1'b1;
            end
        end
        return found;
    endfunction

    task automatic apply_sched_item(input logic [S_TUSER_W-1:0] op,
                                    input logic [S_TDATA_W-1:0] d);
        logic [PROC_W-1:0] idx;
        logic [PROC_W-1:0] pick;
        logic [TICK_W:0]   next_tick;
        logic              resched;
        logic              picked;
        sched_status_t     res;
        idx     = d[S_IDX_LSB +: PROC_W];
        resched = 1'b0;
        picked  = 1'b0;
        case (op)
            OP_TICK: begin
                next_tick = {1'b0, tick_cnt} + (TICK_W+1)'(1);
                tick_cnt  = (next_tick >= {1'b0, wrap_limit}) ? '0 : next_tick[TICK_W-1:0];
                if (slice_tab[cur_sel] != 0) begin
                    slice_tab[cur_sel] = slice_tab[cur_sel] - FIELD_W'(1);
                end
                if (!d[S_NEST_BIT] && slice_tab[cur_sel] == 0) begin
                    resched = 1'b1;
                end
            end
            OP_WRITE: begin
                run_tab[idx]   = d[S_RUN_BIT];
                prio_tab[idx]  = d[S_PRIO_LSB +: FIELD_W];
                slice_tab[idx] = d[S_SLICE_LSB +: FIELD_W];
            end
            OP_BLOCK: begin
                resched = 1'b1;
            end
            default: begin
            end
        endcase
        if (resched) begin
            picked = find_longest(pick);
            if (!picked) begin
                // Every runnable slice is spent, so all of them are reloaded.
                for (int i = 0; i < NUM_PROCS; i++) begin
                    if (run_tab[i]) begin
                        slice_tab[i] = prio_tab[i];
                    end
                end
                picked = find_longest(pick);
            end
            if (picked) begin
                cur_sel = pick;
            end
        end
        res.proc       = cur_sel;
        res.slice      = slice_tab[cur_sel];
        res.tick       = tick_cnt;
        res.switched   = resched && picked;
        res.none_ready = resched && !picked;
        status_q.push_back(res);
    endtask

    task automatic compare_field(input string name, input logic [TICK_W-1:0] exp_val,
                                 input logic [TICK_W-1:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        sched_status_t exp_res;
        if (!aresetn) begin
            for (int i = 0; i < NUM_PROCS; i++) begin
                slice_tab[i] = '0;
                prio_tab[i]  = '0;
                run_tab[i]   = 1'b0;
            end
            cur_sel    = '0;
            tick_cnt   = '0;
            wrap_limit = '1;
            status_q.delete();
        end else begin
            if (cfg_wr_en) begin
                wrap_limit = cfg_wr_data;
            end
            if (s_tvalid && s_tready) begin
                apply_sched_item(s_tuser, s_tdata);
            end
            if (m_tvalid && m_tready) begin
                if (status_q.size() == 0) begin
                    $error("result transaction arrived with no expectation pending");
                    errors++;
                end else begin
                    exp_res = status_q.pop_front();
                    compare_field("current_proc", TICK_W'(exp_res.proc),
                                  TICK_W'(m_tdata[M_PROC_LSB +: PROC_W]));
                    compare_field("current_slice", TICK_W'(exp_res.slice),
                                  TICK_W'(m_tdata[M_SLICE_LSB +: FIELD_W]));
                    compare_field("tick_count", exp_res.tick,
                                  m_tdata[M_TICK_LSB +: TICK_W]);
                    compare_field("switched", TICK_W'(exp_res.switched),
                                  TICK_W'(m_tdata[M_SWITCH_BIT]));
                    compare_field("none_ready", TICK_W'(exp_res.none_ready),
                                  TICK_W'(m_tdata[M_NONE_BIT]));
                end
            end
        end
        pending_cnt <= status_q.size();
        fail_count  <= errors;
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import tps_pkg::*;

    localparam logic [S_TUSER_W-1:0] OP_UNUSED = 2'd3;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int STALL_CYCLES = 400;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [TICK_W-1:0]    cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    int                   fail_count;
    int                   pending_cnt;
    int                   cycle_cnt = 0;
    int                   tx_idle_pct = 0;
    int                   rx_idle_pct = 0;
    logic                 stall_go = 1'b0;
    logic                 stall_done = 1'b0;
    int                   stall_cnt = 0;

    tick_priority_scheduler DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    sched_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .pending_cnt (pending_cnt)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // The receiver holds off once for a long stretch so the block backs up.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            stall_cnt <= 0;
        end else if (stall_cnt != 0) begin
            stall_cnt <= stall_cnt - 1;
            m_tready  <= 1'b0;
        end else if (stall_go && !stall_done) begin
            stall_cnt  <= STALL_CYCLES;
            stall_done <= 1'b1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_item(input logic [S_TUSER_W-1:0] op, input logic [PROC_W-1:0] idx,
                             input logic run, input logic [FIELD_W-1:0] prio,
                             input logic [FIELD_W-1:0] slice, input logic nest);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tuser  <= op;
        s_tdata  <= {2'b00, nest, slice, prio, run, idx};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_random(input int count);
        logic [S_TUSER_W-1:0] op;
        logic [FIELD_W-1:0]   prio;
        logic [FIELD_W-1:0]   slice;
        logic                 nest;
        int                   r;
        for (int n = 0; n < count; n++) begin
            r     = $urandom_range(99);
            op    = (r < 50) ? OP_TICK : (r < 78) ? OP_WRITE : (r < 96) ? OP_BLOCK : OP_UNUSED;
            prio  = FIELD_W'($urandom);
            slice = FIELD_W'($urandom);
            if ($urandom_range(99) < 70) begin
                prio = FIELD_W'($urandom_range(5));
            end
            if ($urandom_range(99) < 70) begin
                slice = FIELD_W'($urandom_range(4));
            end
            nest = (op == OP_TICK) ? ($urandom_range(99) < 20) : 1'($urandom_range(1));
            send_item(op, PROC_W'($urandom_range(15)), ($urandom_range(99) < 75),
                      prio, slice, nest);
        end
    endtask

    task automatic drain_and_config(input logic [TICK_W-1:0] limit);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_cnt != 0) begin
            @(posedge aclk);
        end
        repeat (40) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= limit;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = OP_TICK;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        tx_idle_pct = 7;
        rx_idle_pct <= 72;
        drain_and_config(32'hFFFF_FFFF);
        send_item(OP_TICK, 4'd0, 1'b0, 16'd0, 16'd0, 1'b0);
        send_item(OP_BLOCK, 4'd0, 1'b0, 16'd0, 16'd0, 1'b0);
        send_item(OP_UNUSED, 4'd0, 1'b0, 16'd0, 16'd0, 1'b0);
        send_item(OP_WRITE, 4'd0, 1'b1, 16'hFFFF, 16'd0, 1'b1);
        send_item(OP_WRITE, 4'd15, 1'b1, 16'd2, 16'hFFFF, 1'b0);
        send_item(OP_WRITE, 4'd7, 1'b0, 16'hFFFF, 16'hFFFF, 1'b0);
        send_item(OP_BLOCK, 4'd0, 1'b0, 16'd0, 16'd0, 1'b0);
        send_item(OP_TICK, 4'd0, 1'b0, 16'd0, 16'd0, 1'b1);
        send_item(OP_WRITE, 4'd15, 1'b1, 16'd0, 16'd1, 1'b0);
        send_item(OP_TICK, 4'd0, 1'b0, 16'd0, 16'd0, 1'b0);
        send_item(OP_BLOCK, 4'd0, 1'b0, 16'd0, 16'd0, 1'b0);
        send_item(OP_WRITE, 4'd0, 1'b1, 16'd0, 16'd0, 1'b0);
        send_item(OP_TICK, 4'd0, 1'b0, 16'd0, 16'd0, 1'b0);
        send_item(OP_TICK, 4'd0, 1'b0, 16'd0, 16'd0, 1'b1);
        send_item(OP_WRITE, 4'd3, 1'b1, 16'd3, 16'd3, 1'b0);
        send_item(OP_WRITE, 4'd9, 1'b1, 16'd3, 16'd3, 1'b0);
        send_item(OP_BLOCK, 4'd0, 1'b0, 16'd0, 16'd0, 1'b0);
        send_item(OP_TICK, 4'd0, 1'b0, 16'd0, 16'd0, 1'b0);
        send_item(OP_TICK, 4'd0, 1'b0, 16'd0, 16'd0, 1'b0);
        send_item(OP_TICK, 4'd0, 1'b0, 16'd0, 16'd0, 1'b0);
        send_item(OP_UNUSED, 4'd15, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1);
        send_item(OP_WRITE, 4'd15, 1'b0, 16'hFFFF, 16'hFFFF, 1'b1);
        send_random(320);

        tx_idle_pct = 72;
        rx_idle_pct <= 7;
        drain_and_config(32'd7);
        send_random(320);

        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        drain_and_config(32'd1);
        send_random(20);
        drain_and_config(32'd0);
        send_random(20);
        drain_and_config(32'd23);
        stall_go <= 1'b1;
        send_random(290);

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_cnt != 0) begin
            @(posedge aclk);
        end
        repeat (50) @(posedge aclk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/tps_pkg.sv
rtl/core/tps_cell.sv
rtl/core/tick_priority_scheduler.sv
rtl/core/tps_checker.sv
test/sched_checker.sv
test/tb_top.sv
